### design/mfc_pkg.sv
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared widths, codes and constants for the magnetometer smoothing and
// hard-iron calibration block.
// ----------------------------------------------------------------------------
package mfc_pkg;

  // Sample and accumulator widths
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 21;
  localparam int INCR_W   = 33;
  localparam int ANGLE_W  = 40;

  // Divide by ten: multiply by ceil(2^24 / 10), keep bits from 24 up.
  // Exact for magnitudes below 2^22, well above the accumulator range.
  localparam int               DIV10_SHIFT = 24;
  localparam logic [SUM_W-1:0] DIV10_MUL   = 21'd1677722;

  // Angle fraction bits (2^-24 degree units)
  localparam int ANGLE_FRAC = 24;

  // Fault check: limits of magnitude below SMALL_LIMIT are suspect
  localparam int SMALL_LIMIT     = 20;
  localparam int SMALL_COUNT_MIN = 5;

  // Calibration phases
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_Z    = 2'd1;
  localparam logic [1:0] PHASE_X    = 2'd2;
  localparam logic [1:0] PHASE_Y    = 2'd3;

  // Axis slots in per-axis arrays
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  // Configuration port
  localparam int               CFG_IDX_W          = 2;
  localparam int               CFG_DATA_W         = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT        = 2'd2;

  localparam logic [15:0] ANGLE_GAIN_RESET     = 16'd2048;
  localparam logic [9:0]  TURN_THRESHOLD_RESET = 10'd150;
  localparam logic [14:0] UPRIGHT_RESET        = 15'd5000;

  // Status of the calibration stage after one item
  typedef struct packed {
    logic       fault;
    logic [1:0] phase;
  } cal_status_t;

endpackage

### design/mfc_smooth.sv
// ----------------------------------------------------------------------------
// mfc_smooth
// Per-axis smoothing: sum = sum - sum/10 + raw, filtered = sum/10, with
// division truncating toward zero. The quotient of the stored sum is kept
// so that each item needs one constant multiply per axis.
// ----------------------------------------------------------------------------
module mfc_smooth (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic signed [15:0]   raw [3],
  output logic signed [15:0]   filt [3]
);
  import mfc_pkg::*;

  logic signed [SUM_W-1:0]      sum [3];
  logic signed [SAMPLE_W-1:0]   quot [3];
  logic signed [SUM_W-1:0]      sum_next [3];
  logic [SUM_W-1:0]             mag [3];
  logic [2*SUM_W-1:0]           prod [3];
  logic [SAMPLE_W-1:0]          qmag [3];

  // Update the sum and divide the new sum by ten
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_next[i] = sum[i] - SUM_W'(quot[i]) + SUM_W'(raw[i]);
      mag[i]      = sum_next[i][SUM_W-1] ? SUM_W'(-sum_next[i]) : SUM_W'(sum_next[i]);
      prod[i]     = mag[i] * DIV10_MUL;
      qmag[i]     = prod[i][DIV10_SHIFT +: SAMPLE_W];
      filt[i]     = sum_next[i][SUM_W-1] ? -$signed(qmag[i]) : $signed(qmag[i]);
    end
  end

  // Hold the sum and its quotient; advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sum[i]  <= '0;
        quot[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < 3; i++) begin
        sum[i]  <= sum_next[i];
        quot[i] <= filt[i];
      end
    end
  end

endmodule

### design/mfc_calib.sv
// ----------------------------------------------------------------------------
// mfc_calib
// Hard-iron calibration: min/max tracking per axis, three gyro turn phases,
// the small-limit fault check and the offset-corrected, saturated output.
// ----------------------------------------------------------------------------
module mfc_calib (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic signed [15:0]         filt [3],
  input  logic signed [32:0]         incr [3],
  input  logic                       start,
  input  logic [9:0]                 turn_threshold,
  output logic signed [15:0]         heading [3],
  output mfc_pkg::cal_status_t       status
);
  import mfc_pkg::*;

  // State
  logic signed [SAMPLE_W-1:0] lim_min [3];
  logic signed [SAMPLE_W-1:0] lim_max [3];
  logic signed [ANGLE_W-1:0]  angle [3];
  logic [1:0]                 phase;
  logic                       clear_pending;
  logic                       check_pending;
  logic                       fault;

  // Next values and intermediates
  logic signed [SAMPLE_W-1:0] lim_min_next [3];
  logic signed [SAMPLE_W-1:0] lim_max_next [3];
  logic signed [ANGLE_W-1:0]  angle_next [3];
  logic signed [SAMPLE_W-1:0] min_base [3];
  logic signed [SAMPLE_W-1:0] max_base [3];
  logic signed [ANGLE_W-1:0]  ang_base [3];
  logic signed [ANGLE_W-1:0]  ang_cand [3];
  logic [ANGLE_W-1:0]         ang_mag [3];
  logic [2:0]                 turn_done;
  logic [ANGLE_W-1:0]         thr_full;
  logic [1:0]                 phase_eff;
  logic [1:0]                 phase_next;
  logic                       active;
  logic                       clr;
  logic                       clear_pending_next;
  logic                       check_pending_next;
  logic                       check_eff;
  logic                       fault_next;
  logic [2:0]                 small_cnt;
  logic signed [SAMPLE_W:0]   mid_sum [3];
  logic signed [SAMPLE_W:0]   mid_half [3];
  logic signed [SAMPLE_W+1:0] diff [3];

  // Limits, angles and phase sequencing
  always_comb begin
    phase_eff = (start && phase == PHASE_IDLE) ? PHASE_Z : phase;
    active    = (phase_eff != PHASE_IDLE);
    clr       = active && clear_pending;
    thr_full  = ANGLE_W'(turn_threshold) << ANGLE_FRAC;

    for (int i = 0; i < 3; i++) begin
      min_base[i] = clr ? '0 : lim_min[i];
      max_base[i] = clr ? '0 : lim_max[i];
      ang_base[i] = clr ? '0 : angle[i];

      lim_min_next[i] = min_base[i];
      lim_max_next[i] = max_base[i];
      if (active) begin
        if (min_base[i] > filt[i]) begin
          lim_min_next[i] = filt[i];
        end else if (max_base[i] < filt[i]) begin
          lim_max_next[i] = filt[i];
        end
      end

      ang_cand[i]   = ang_base[i] + ANGLE_W'(incr[i]);
      ang_mag[i]    = ang_cand[i][ANGLE_W-1] ? ANGLE_W'(-ang_cand[i]) : ANGLE_W'(ang_cand[i]);
      turn_done[i]  = (ang_mag[i] > thr_full);
      angle_next[i] = ang_base[i];
    end

    // Phases run in order Z, X, Y; a finished phase lets the next one run
    phase_next         = phase_eff;
    clear_pending_next = clr ? 1'b0 : clear_pending;
    if (phase_next == PHASE_Z) begin
      angle_next[AX_Z] = ang_cand[AX_Z];
      if (turn_done[AX_Z]) phase_next = PHASE_X;
    end
    if (phase_next == PHASE_X) begin
      angle_next[AX_X] = ang_cand[AX_X];
      if (turn_done[AX_X]) phase_next = PHASE_Y;
    end
    if (phase_next == PHASE_Y) begin
      angle_next[AX_Y] = ang_cand[AX_Y];
      if (turn_done[AX_Y]) begin
        phase_next         = PHASE_IDLE;
        clear_pending_next = 1'b1;
      end
    end
  end

  // Fault check on the updated limits
  always_comb begin
    small_cnt = '0;
    for (int i = 0; i < 3; i++) begin
      small_cnt = small_cnt
                + 3'((lim_min_next[i] > -SMALL_LIMIT) && (lim_min_next[i] < SMALL_LIMIT))
                + 3'((lim_max_next[i] > -SMALL_LIMIT) && (lim_max_next[i] < SMALL_LIMIT));
    end
    // The check runs while calibrating and once after reset; either way it is done now
    check_eff          = active || check_pending;
    check_pending_next = 1'b0;
    fault_next         = check_eff ? (small_cnt >= 3'(SMALL_COUNT_MIN)) : fault;
  end

  // Offset-corrected output, saturated to 16 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mid_sum[i]  = (SAMPLE_W+1)'(lim_max_next[i]) + (SAMPLE_W+1)'(lim_min_next[i]);
      mid_half[i] = (mid_sum[i] + $signed({{SAMPLE_W{1'b0}}, mid_sum[i][SAMPLE_W]})) >>> 1;
      diff[i]     = (SAMPLE_W+2)'(filt[i]) - (SAMPLE_W+2)'(mid_half[i]);
      if (diff[i] > 18'sd32767) begin
        heading[i] = 16'sh7FFF;
      end else if (diff[i] < -18'sd32768) begin
        heading[i] = 16'sh8000;
      end else begin
        heading[i] = diff[i][SAMPLE_W-1:0];
      end
    end
    status.fault = fault_next;
    status.phase = phase_next;
  end

  // Hold calibration state; advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        lim_min[i] <= '0;
        lim_max[i] <= '0;
        angle[i]   <= '0;
      end
      phase         <= PHASE_IDLE;
      clear_pending <= 1'b1;
      check_pending <= 1'b1;
      fault         <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < 3; i++) begin
        lim_min[i] <= lim_min_next[i];
        lim_max[i] <= lim_max_next[i];
        angle[i]   <= angle_next[i];
      end
      phase         <= phase_next;
      clear_pending <= clear_pending_next;
      check_pending <= check_pending_next;
      fault         <= fault_next;
    end
  end

endmodule

### design/magnetometer_filter_calibrate.sv
// ----------------------------------------------------------------------------
// magnetometer_filter_calibrate
// Path: input register, smoothing stage and stage B register, then the
//   calibration stage into the output register.
// Throughput: one item per cycle while out_ready holds; each stage moves whenever the next is free.
// Reset: synchronous; clears filter sums, limits, angles and phase, arms the
//   first fault check and restores register defaults (2048, 150, 5000).
// ----------------------------------------------------------------------------
module magnetometer_filter_calibrate (
  input  logic                clk,
  input  logic                rst,
  // Configuration writes
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  raw_x,
  input  logic signed [15:0]  raw_y,
  input  logic signed [15:0]  raw_z,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  rate_x,
  input  logic signed [15:0]  rate_y,
  input  logic signed [15:0]  rate_z,
  input  logic                start_cal,
  // Output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  heading_x,
  output logic signed [15:0]  heading_y,
  output logic signed [15:0]  heading_z,
  output logic                mag_fault,
  output logic [1:0]          cal_phase
);
  import mfc_pkg::*;

  // Configuration registers
  logic [15:0] angle_gain;
  logic [9:0]  turn_threshold;
  logic [14:0] upright_threshold;

  // Stage A: input register
  logic                       a_valid;
  logic signed [SAMPLE_W-1:0] a_raw [3];
  logic signed [SAMPLE_W-1:0] a_accel [3];
  logic signed [SAMPLE_W-1:0] a_rate [3];
  logic                       a_start;

  // Stage B: filtered samples and gated angle increments
  logic                       b_valid;
  logic signed [SAMPLE_W-1:0] b_filt [3];
  logic signed [INCR_W-1:0]   b_incr [3];
  logic                       b_start;

  // Handshake
  logic in_fire;
  logic a_fire;
  logic b_fire;
  logic out_fire;

  // Stage A logic
  logic signed [SAMPLE_W-1:0] a_filt [3];
  logic [SAMPLE_W:0]          accel_mag [3];
  logic                       upright [3];
  logic signed [INCR_W-1:0]   prod [3];
  logic signed [INCR_W-1:0]   incr [3];

  // Stage B logic
  logic signed [SAMPLE_W-1:0] heading [3];
  cal_status_t                status;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_gain        <= ANGLE_GAIN_RESET;
      turn_threshold    <= TURN_THRESHOLD_RESET;
      upright_threshold <= UPRIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_GAIN:     angle_gain        <= cfg_data;
        CFG_TURN_THRESHOLD: turn_threshold    <= cfg_data[9:0];
        CFG_UPRIGHT:        upright_threshold <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes: a stage loads when it is empty or its item moves on
  always_comb begin
    out_fire = out_valid & out_ready;
    b_fire   = b_valid & (~out_valid | out_ready);
    a_fire   = a_valid & (~b_valid | b_fire);
    in_ready = ~a_valid | a_fire;
    in_fire  = in_valid & in_ready;
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) a_valid <= 1'b1;
      else if (a_fire) a_valid <= 1'b0;
      if (a_fire) b_valid <= 1'b1;
      else if (b_fire) b_valid <= 1'b0;
      if (b_fire) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_raw[AX_X]   <= raw_x;
      a_raw[AX_Y]   <= raw_y;
      a_raw[AX_Z]   <= raw_z;
      a_accel[AX_X] <= accel_x;
      a_accel[AX_Y] <= accel_y;
      a_accel[AX_Z] <= accel_z;
      a_rate[AX_X]  <= rate_x;
      a_rate[AX_Y]  <= rate_y;
      a_rate[AX_Z]  <= rate_z;
      a_start       <= start_cal;
    end
  end

  // Smoothing filter
  mfc_smooth u_smooth (
    .clk  (clk),
    .rst  (rst),
    .en   (a_fire),
    .raw  (a_raw),
    .filt (a_filt)
  );

  // Gyro increments, dropped unless the axis is held upright
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      accel_mag[i] = a_accel[i][SAMPLE_W-1] ? (SAMPLE_W+1)'(-a_accel[i])
                                            : (SAMPLE_W+1)'(a_accel[i]);
      upright[i]   = accel_mag[i] > (SAMPLE_W+1)'(upright_threshold);
      prod[i]      = a_rate[i] * $signed({1'b0, angle_gain});
      incr[i]      = upright[i] ? prod[i] : '0;
    end
  end

  // Advance stage A into stage B
  always_ff @(posedge clk) begin
    if (a_fire) begin
      for (int i = 0; i < 3; i++) begin
        b_filt[i] <= a_filt[i];
        b_incr[i] <= incr[i];
      end
      b_start <= a_start;
    end
  end

  // Calibration and offset correction
  mfc_calib u_calib (
    .clk            (clk),
    .rst            (rst),
    .en             (b_fire),
    .filt           (b_filt),
    .incr           (b_incr),
    .start          (b_start),
    .turn_threshold (turn_threshold),
    .heading        (heading),
    .status         (status)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (b_fire) begin
      heading_x <= heading[AX_X];
      heading_y <= heading[AX_Y];
      heading_z <= heading[AX_Z];
      mag_fault <= status.fault;
      cal_phase <= status.phase;
    end
  end

endmodule
